FILE: design/fcdx_pkg.sv
// Shared types and constants for the crossfading feedback comb.
package fcdx_pkg;

  // Field widths fixed by the interface
  localparam int unsigned SAMPLE_W   = 24;
  localparam int unsigned REQ_W      = 14;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned STEP_W     = 17;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_STEP     = 2'd1;

  // Reset values and fade constants (Q1.16)
  localparam logic [GAIN_W-1:0] GAIN_RST      = 16'd0;
  localparam logic [STEP_W-1:0] FADE_STEP_RST = 17'd655;
  localparam logic [STEP_W-1:0] FADE_ONE      = 17'h10000;
  localparam logic [STEP_W-1:0] FADE_MIN_STEP = 17'd1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clear;    // write zero at the sweep address
    logic accept;   // latch sample, decide delay switch
    logic rd_cur;   // read tap at current delay
    logic rd_old;   // read tap at previous delay, hold current tap
    logic mix;      // multiply tap difference by fade weight
    logic feed;     // finish blend, multiply by feedback gain
    logic wr;       // write store, load result register
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clear_last;  // sweep address at the last entry
  } dp_status_t;

endpackage

FILE: design/fcdx_ctrl.sv
// Controller: clearing sweep, item sequencing and the output valid flag.
module fcdx_ctrl
  import fcdx_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_RD_CUR = 7'b0000100,
    ST_RD_OLD = 7'b0001000,
    ST_MIX    = 7'b0010000,
    ST_FEED   = 7'b0100000,
    ST_WRITE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_RD_CUR;
        end
      end
      ST_RD_CUR: begin
        cmd_o.rd_cur = 1'b1;
        state_d      = ST_RD_OLD;
      end
      ST_RD_OLD: begin
        cmd_o.rd_old = 1'b1;
        state_d      = ST_MIX;
      end
      ST_MIX: begin
        cmd_o.mix = 1'b1;
        state_d   = ST_FEED;
      end
      ST_FEED: begin
        cmd_o.feed = 1'b1;
        state_d    = ST_WRITE;
      end
      ST_WRITE: begin
        // hold until the result register is free
        if (out_free) begin
          cmd_o.wr = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Drop a taken beat, raise on a new result
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd_o.wr) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

FILE: design/fcdx_datapath.sv
// Datapath: delay store, delay and fade state, crossfade and feedback arithmetic.
module fcdx_datapath
  import fcdx_pkg::*;
#(
  parameter int unsigned DELAY_DEPTH = 8192
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dp_cmd_t               cmd_i,
  output dp_status_t            status_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [SAMPLE_W-1:0]   sample_in_i,
  input  logic [REQ_W-1:0]      delay_request_i,
  output logic [SAMPLE_W-1:0]   sample_out_o
);

  localparam int unsigned AW = $clog2(DELAY_DEPTH);
  localparam int unsigned DW = $clog2(DELAY_DEPTH + 1);
  localparam int unsigned CW = (DW > REQ_W) ? DW : REQ_W;
  localparam int unsigned TW = AW + 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DELAY_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C   = CW'(DELAY_DEPTH);
  localparam logic [TW-1:0] DEPTH_T   = TW'(DELAY_DEPTH);

  localparam logic signed [42:0] MIX_HALF = 43'sd32768;
  localparam logic signed [40:0] FB_HALF  = 41'sd32768;
  localparam logic signed [24:0] S24_MAX  = 25'sd8388607;
  localparam logic signed [24:0] S24_MIN  = -25'sd8388608;

  logic [SAMPLE_W-1:0] mem [DELAY_DEPTH];

  logic [GAIN_W-1:0]   gain_q;
  logic [STEP_W-1:0]   step_q;
  logic [AW-1:0]       wi_q, clr_q;
  logic [DW-1:0]       cur_q, prev_q;
  logic [STEP_W-1:0]   fade_q;
  logic [SAMPLE_W-1:0] x_q, rdata_q, cur_tap_q, y_q, out_q;
  logic signed [42:0]  mix_prod_q;
  logic signed [40:0]  fb_prod_q;

  logic [CW-1:0]       req_ext;
  logic [DW-1:0]       req_c;
  logic                do_switch;
  logic [AW-1:0]       rd_addr, wr_addr;
  logic [SAMPLE_W-1:0] wr_data;
  logic                mem_we;
  logic                mem_re;
  logic [STEP_W-1:0]   eff_step, fade_next;
  logic signed [24:0]  diff;
  logic signed [42:0]  mix_round, mix_shift;
  logic signed [24:0]  y_wide;
  logic signed [SAMPLE_W-1:0] y_d;
  logic signed [40:0]  fb_round, fb_shift;
  logic signed [24:0]  w_wide;
  logic [SAMPLE_W-1:0] w_sat;

  // Store address for a tap at the given delay behind the write pointer
  function automatic logic [AW-1:0] tap_addr(input logic [AW-1:0] wi,
                                             input logic [DW-1:0] dly);
    logic [TW-1:0] t;
    t = TW'(wi) + DEPTH_T - TW'(dly);
    if (t >= DEPTH_T) t = t - DEPTH_T;
    return t[AW-1:0];
  endfunction

  // Clamp the request to 1..DELAY_DEPTH
  always_comb begin
    req_ext = CW'(delay_request_i);
    if (req_ext == '0) req_ext = CW'(1);
    else if (req_ext > DEPTH_C) req_ext = DEPTH_C;
    req_c = req_ext[DW-1:0];
  end

  assign do_switch = (req_c != cur_q) && (fade_q == '0);

  // Fade weight after one blended sample
  always_comb begin
    eff_step  = (step_q == '0) ? FADE_MIN_STEP : step_q;
    fade_next = (fade_q > eff_step) ? (fade_q - eff_step) : '0;
  end

  // Crossfade: cur + rnd((old - cur) * fade / 65536)
  assign diff      = $signed({rdata_q[SAMPLE_W-1], rdata_q}) -
                     $signed({cur_tap_q[SAMPLE_W-1], cur_tap_q});
  assign mix_round = mix_prod_q + MIX_HALF;
  assign mix_shift = mix_round >>> 16;
  assign y_wide    = $signed({cur_tap_q[SAMPLE_W-1], cur_tap_q}) + mix_shift[24:0];
  assign y_d       = y_wide[SAMPLE_W-1:0];

  // Feedback: sat24(x + rnd(gain * y / 65536))
  assign fb_round = fb_prod_q + FB_HALF;
  assign fb_shift = fb_round >>> 16;
  assign w_wide   = $signed({x_q[SAMPLE_W-1], x_q}) + fb_shift[24:0];
  always_comb begin
    if (w_wide > S24_MAX)      w_sat = S24_MAX[SAMPLE_W-1:0];
    else if (w_wide < S24_MIN) w_sat = S24_MIN[SAMPLE_W-1:0];
    else                       w_sat = w_wide[SAMPLE_W-1:0];
  end

  // Memory port selection
  assign rd_addr = cmd_i.rd_old ? tap_addr(wi_q, prev_q) : tap_addr(wi_q, cur_q);
  assign mem_re  = cmd_i.rd_cur || cmd_i.rd_old;
  assign mem_we  = cmd_i.clear || cmd_i.wr;
  assign wr_addr = cmd_i.clear ? clr_q : wi_q;
  assign wr_data = cmd_i.clear ? '0 : w_sat;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    if (mem_re) rdata_q <= mem[rd_addr];
  end

  // Control-side state: config, pointers, delays, fade weight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RST;
      step_q <= FADE_STEP_RST;
      wi_q   <= '0;
      clr_q  <= '0;
      cur_q  <= DW'(DELAY_DEPTH);
      prev_q <= DW'(DELAY_DEPTH);
      fade_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_FEEDBACK_GAIN: gain_q <= cfg_data_i[GAIN_W-1:0];
          CFG_FADE_STEP:     step_q <= cfg_data_i[STEP_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.clear) clr_q <= (clr_q == LAST_ADDR) ? '0 : clr_q + AW'(1);
      if (cmd_i.accept && do_switch) begin
        prev_q <= cur_q;
        cur_q  <= req_c;
        fade_q <= FADE_ONE;
      end
      if (cmd_i.mix) fade_q <= fade_next;
      if (cmd_i.wr) wi_q <= (wi_q == LAST_ADDR) ? '0 : wi_q + AW'(1);
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) x_q <= sample_in_i;
    if (cmd_i.rd_old) cur_tap_q <= rdata_q;
    if (cmd_i.mix)    mix_prod_q <= diff * $signed({1'b0, fade_q});
    if (cmd_i.feed) begin
      y_q       <= y_d;
      fb_prod_q <= y_d * $signed({1'b0, gain_q});
    end
    if (cmd_i.wr) out_q <= y_q;
  end

  assign status_o.clear_last = (clr_q == LAST_ADDR);
  assign sample_out_o        = out_q;

endmodule

FILE: design/feedback_comb_with_delay_crossfade.sv
// Top level of the feedback comb with crossfaded delay changes.
//
//   channel  direction  handshake                payload
//   input    in         in_valid_i / in_stall_o  sample_in_i, delay_request_i
//   output   out        out_valid_o / out_stall_i sample_out_o
//   config   in         cfg_we_i (no wait)       cfg_index_i, cfg_data_i
//
// Each item steps through accept, two reads of the single-read-port delay
// store, the crossfade multiply, the feedback multiply, and the store write.
// After reset the store is swept to zero, one entry per cycle, across all
// DELAY_DEPTH entries; in_stall_o stays high meanwhile and config writes still land.
// The result register lets a new beat be accepted while the last result waits;
// the write step holds while that register is still full and stalled.
module feedback_comb_with_delay_crossfade
  import fcdx_pkg::*;
#(
  parameter int unsigned DELAY_DEPTH = 8192
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [SAMPLE_W-1:0]   sample_in_i,
  input  logic [REQ_W-1:0]      delay_request_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [SAMPLE_W-1:0]   sample_out_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  fcdx_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  fcdx_datapath #(
    .DELAY_DEPTH (DELAY_DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .sample_in_i     (sample_in_i),
    .delay_request_i (delay_request_i),
    .sample_out_o    (sample_out_o)
  );

endmodule
